// ----- src/pdsd_pkg.sv -----
// ----------------------------------------------------------------------------
// pdsd_pkg
// Shared types, constants and the half-step coil table for the pulse
// decoder with stepper drive.
// ----------------------------------------------------------------------------
package pdsd_pkg;

	localparam int TICK_BITS  = 16;
	localparam int TIME_W     = 16;
	localparam int CMP_W      = (TICK_BITS > TIME_W) ? TICK_BITS : TIME_W;
	localparam int STEP_W     = 8;
	localparam int PERIOD_W   = 8;
	localparam int COIL_W     = 4;
	localparam int PHASE_W    = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [TIME_W-1:0]   ERROR_TIME_RST  = TIME_W'(500);
	localparam logic [TIME_W-1:0]   START_TIME_RST  = TIME_W'(275);
	localparam logic [TIME_W-1:0]   STOP_TIME_RST   = TIME_W'(300);
	localparam logic [TIME_W-1:0]   STATE_TIME_RST  = TIME_W'(200);
	localparam logic [STEP_W-1:0]   STEP_COUNT_RST  = STEP_W'(50);
	localparam logic [PERIOD_W-1:0] DEADTIME_RST    = PERIOD_W'(5);
	localparam logic [PERIOD_W-1:0] PHASE_DELAY_RST = PERIOD_W'(20);

	localparam logic [PHASE_W-1:0] PHASE_RST   = PHASE_W'(1);
	localparam logic [PHASE_W-1:0] PHASE_FIRST = PHASE_W'(1);
	localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(8);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ERROR_TIME  = 3'd0,
		CFG_START_TIME  = 3'd1,
		CFG_STOP_TIME   = 3'd2,
		CFG_STATE_TIME  = 3'd3,
		CFG_STEP_COUNT  = 3'd4,
		CFG_DEADTIME    = 3'd5,
		CFG_PHASE_DELAY = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	typedef struct packed {
		logic [TIME_W-1:0]   error_time;
		logic [TIME_W-1:0]   start_time;
		logic [TIME_W-1:0]   stop_time;
		logic [TIME_W-1:0]   state_time;
		logic [STEP_W-1:0]   step_count;
		logic [PERIOD_W-1:0] deadtime;
		logic [PERIOD_W-1:0] phase_delay;
	} cfg_t;

	// decoder -> stepper: a change of the decoded bit starts a new run
	typedef struct packed {
		logic start;
		logic fwd;
	} run_req_t;

	// half-step sequence, entries 1..8; bit3 AP, bit2 AN, bit1 BP, bit0 BN
	function automatic logic [COIL_W-1:0] coil_lookup(input logic [PHASE_W-1:0] idx);
		logic [COIL_W-1:0] c;
		unique case (idx)
			4'd1:    c = 4'd1;
			4'd2:    c = 4'd5;
			4'd3:    c = 4'd4;
			4'd4:    c = 4'd6;
			4'd5:    c = 4'd2;
			4'd6:    c = 4'd10;
			4'd7:    c = 4'd8;
			4'd8:    c = 4'd9;
			default: c = 4'd0;
		endcase
		return c;
	endfunction

endpackage

// ----- src/pulse_decoder_with_stepper_drive.sv -----
// ----------------------------------------------------------------------------
// pulse_decoder_with_stepper_drive
// Serial pulse-width decoder for a daisy chain with a half-step stepper drive.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): op = 0 is a timer tick carrying the
// sampled line level in data_in; op = 1 is a stepper timer event. Every
// input transfer yields exactly one result transfer on the output channel
// (out_valid/out_stall) carrying data_out, coils, next_period, motor_idle
// and sequin_bit as they stand after that item.
// The item is captured in an input register; the state update and the
// result register load happen as it moves on from there.
// Throughput is one item per clock while the receiver does not stall; the
// state update is a single short compare-and-select step between the input
// and result registers. When the receiver stalls, the result register
// holds its value and the input register can still take one more item;
// in_stall rises only once both are full.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken; indexes beyond the register list are ignored. Write only while idle.
// Reset (arst_n low) restores register defaults, the decoder to idle, the
// stepper's coil and period state (coils off, short period) and both channels empty.
// ----------------------------------------------------------------------------
module pulse_decoder_with_stepper_drive (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               op,
	input  logic                               data_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               data_out,
	output logic [pdsd_pkg::COIL_W-1:0]        coils,
	output logic [pdsd_pkg::PERIOD_W-1:0]      next_period,
	output logic                               motor_idle,
	output logic                               sequin_bit,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pdsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pdsd_pkg::*;

	cfg_t     cfg_q;
	logic     valid_s1, op_s1, din_s1;
	logic     valid_s2;
	logic     out_free, adv;
	logic     in_xfer;
	logic     out_level_nxt, bit_nxt, idle_nxt;
	logic [COIL_W-1:0]   coils_nxt;
	logic [PERIOD_W-1:0] period_nxt;
	run_req_t run;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_time  <= ERROR_TIME_RST;
			cfg_q.start_time  <= START_TIME_RST;
			cfg_q.stop_time   <= STOP_TIME_RST;
			cfg_q.state_time  <= STATE_TIME_RST;
			cfg_q.step_count  <= STEP_COUNT_RST;
			cfg_q.deadtime    <= DEADTIME_RST;
			cfg_q.phase_delay <= PHASE_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ERROR_TIME:  cfg_q.error_time  <= cfg_data[TIME_W-1:0];
				CFG_START_TIME:  cfg_q.start_time  <= cfg_data[TIME_W-1:0];
				CFG_STOP_TIME:   cfg_q.stop_time   <= cfg_data[TIME_W-1:0];
				CFG_STATE_TIME:  cfg_q.state_time  <= cfg_data[TIME_W-1:0];
				CFG_STEP_COUNT:  cfg_q.step_count  <= cfg_data[STEP_W-1:0];
				CFG_DEADTIME:    cfg_q.deadtime    <= cfg_data[PERIOD_W-1:0];
				CFG_PHASE_DELAY: cfg_q.phase_delay <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// result register frees up when empty or being taken this cycle
	assign out_free = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) valid_s2 <= 1'b1;
			else if (out_free) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1  <= op;
			din_s1 <= data_in;
		end
	end

	pdsd_decoder u_decoder (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (adv && !op_s1),
		.din           (din_s1),
		.cfg           (cfg_q),
		.out_level_nxt (out_level_nxt),
		.bit_nxt       (bit_nxt),
		.run           (run)
	);

	pdsd_stepper u_stepper (
		.clk        (clk),
		.arst_n     (arst_n),
		.event_en   (adv && op_s1),
		.run        (run),
		.cfg        (cfg_q),
		.coils_nxt  (coils_nxt),
		.period_nxt (period_nxt),
		.idle_nxt   (idle_nxt)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			data_out    <= out_level_nxt;
			coils       <= coils_nxt;
			next_period <= period_nxt;
			motor_idle  <= idle_nxt;
			sequin_bit  <= bit_nxt;
		end
	end

	assign out_valid = valid_s2;

endmodule

// ----- src/pdsd_decoder.sv -----
// ----------------------------------------------------------------------------
// pdsd_decoder
// Pulse-width frame decoder: start pulse check, bit sample, gap wait and
// echo of the line onto the chained output. Requests a stepper run on
// every change of the decoded bit.
// ----------------------------------------------------------------------------
module pdsd_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick,
	input  logic              din,
	input  pdsd_pkg::cfg_t    cfg,
	output logic              out_level_nxt,
	output logic              bit_nxt,
	output pdsd_pkg::run_req_t run
);
	import pdsd_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_START = 6'b000010,
		ST_WAIT  = 6'b000100,
		ST_SAMP  = 6'b001000,
		ST_GAP   = 6'b010000,
		ST_ECHO  = 6'b100000
	} dec_state_t;

	dec_state_t           state_q, state_nxt;
	logic [TICK_BITS-1:0] tick_q, tick_nxt;
	logic                 out_level_q, bit_q, bit_prev_q;
	logic                 bit_calc, out_calc, clr;
	logic [CMP_W-1:0]     t;
	logic                 gt_err, gt_start, gt_stop, gt_state;

	assign t        = CMP_W'(tick_q);
	assign gt_err   = t > CMP_W'(cfg.error_time);
	assign gt_start = t > CMP_W'(cfg.start_time);
	assign gt_stop  = t > CMP_W'(cfg.stop_time);
	assign gt_state = t > CMP_W'(cfg.state_time);

	always_comb begin
		state_nxt = state_q;
		bit_calc  = bit_q;
		out_calc  = out_level_q;
		clr       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				clr = 1'b1;
				if (din) state_nxt = ST_START;
			end
			ST_START: begin
				if (gt_err) state_nxt = ST_IDLE;
				// a long enough pulse is accepted even if it also ran too long
				if (!din) begin
					state_nxt = ST_IDLE;
					if (gt_start) begin
						state_nxt = ST_WAIT;
						clr       = 1'b1;
					end
				end
			end
			ST_WAIT: begin
				out_calc = 1'b1;
				if (gt_state) state_nxt = ST_SAMP;
			end
			ST_SAMP: begin
				bit_calc  = din;
				state_nxt = ST_GAP;
			end
			ST_GAP: begin
				if (!din && gt_start) begin
					clr       = 1'b1;
					state_nxt = ST_ECHO;
				end
				// timeout wins; the bit sampled before the gap is kept
				if (gt_err) begin
					state_nxt = ST_IDLE;
					bit_calc  = bit_prev_q;
				end
			end
			ST_ECHO: begin
				if (din) begin
					out_calc = 1'b1;
					clr      = 1'b1;
				end else begin
					out_calc = 1'b0;
				end
				if (gt_stop) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		if (clr) tick_nxt = '0;
		else if (tick_q != {TICK_BITS{1'b1}}) tick_nxt = tick_q + 1'b1;
		else tick_nxt = tick_q;
	end

	assign run.start     = tick && (bit_calc != bit_prev_q);
	assign run.fwd       = bit_calc;
	assign out_level_nxt = tick ? out_calc : out_level_q;
	assign bit_nxt       = tick ? bit_calc : bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			out_level_q <= 1'b0;
			bit_q       <= 1'b0;
			bit_prev_q  <= 1'b0;
		end else if (tick) begin
			state_q     <= state_nxt;
			tick_q      <= tick_nxt;
			out_level_q <= out_calc;
			bit_q       <= bit_calc;
			bit_prev_q  <= bit_calc;
		end
	end

endmodule

// ----- src/pdsd_stepper.sv -----
// ----------------------------------------------------------------------------
// pdsd_stepper
// Half-step stepper sequencer: walks the coil table on each timer event,
// alternates the timer period and shuts the coils off when a run ends.
// ----------------------------------------------------------------------------
module pdsd_stepper (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              event_en,
	input  pdsd_pkg::run_req_t                run,
	input  pdsd_pkg::cfg_t                    cfg,
	output logic [pdsd_pkg::COIL_W-1:0]       coils_nxt,
	output logic [pdsd_pkg::PERIOD_W-1:0]     period_nxt,
	output logic                              idle_nxt
);
	import pdsd_pkg::*;

	logic [PHASE_W-1:0]  phase_q, phase_nxt, phase_mv;
	logic [PERIOD_W-1:0] period_q;
	logic [STEP_W-1:0]   steps_q, steps_nxt;
	dir_t                dir_q, dir_nxt;
	logic                done_q;
	logic [COIL_W-1:0]   coil_q;

	always_comb begin
		unique case (dir_q)
			DIR_FWD: phase_mv = phase_q + 1'b1;
			DIR_REV: phase_mv = phase_q - 1'b1;
			default: phase_mv = phase_q;
		endcase
	end

	always_comb begin
		phase_nxt  = phase_q;
		period_nxt = period_q;
		steps_nxt  = steps_q;
		dir_nxt    = dir_q;
		idle_nxt   = done_q;
		coils_nxt  = coil_q;
		if (run.start) begin
			dir_nxt   = run.fwd ? DIR_FWD : DIR_REV;
			steps_nxt = cfg.step_count;
		end
		if (event_en) begin
			if (steps_q == '0) begin
				idle_nxt  = 1'b1;
				dir_nxt   = DIR_STOP;
				coils_nxt = '0;
			end else begin
				// wrap around the eight table entries
				if (phase_mv == '0) phase_nxt = PHASE_LAST;
				else if (phase_mv > PHASE_LAST) phase_nxt = PHASE_FIRST;
				else phase_nxt = phase_mv;
				if (period_q == cfg.deadtime) period_nxt = cfg.phase_delay;
				else if (period_q == cfg.phase_delay) period_nxt = cfg.deadtime;
				coils_nxt = coil_lookup(phase_nxt);
				steps_nxt = steps_q - 1'b1;
				idle_nxt  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PHASE_RST;
			period_q <= DEADTIME_RST;
			steps_q  <= '0;
			dir_q    <= DIR_STOP;
			done_q   <= 1'b1;
			coil_q   <= '0;
		end else begin
			phase_q  <= phase_nxt;
			period_q <= period_nxt;
			steps_q  <= steps_nxt;
			dir_q    <= dir_nxt;
			done_q   <= idle_nxt;
			coil_q   <= coils_nxt;
		end
	end

endmodule

// ----- src/pdsd_checker.sv -----
// ----------------------------------------------------------------------------
// pdsd_props
// Port-level checks for the pulse decoder with stepper drive, bound to the
// top level.
// ----------------------------------------------------------------------------
module pdsd_props (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               data_out,
	input logic [pdsd_pkg::COIL_W-1:0]        coils,
	input logic [pdsd_pkg::PERIOD_W-1:0]      next_period,
	input logic                               motor_idle,
	input logic                               sequin_bit
);
	import pdsd_pkg::*;

	// held result must not move while the receiver stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(coils)
			&& $stable(next_period) && $stable(motor_idle) && $stable(sequin_bit))
		else $error("result changed during stall");

	// input may only back up when the result side is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// coils are off exactly when the run is complete
	a_idle_coils: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (motor_idle == (coils == '0)))
		else $error("coil drive disagrees with run state");

	// never drive both sides of one H-bridge
	a_no_shoot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(coils[3] && coils[2]) && !(coils[1] && coils[0]))
		else $error("H-bridge shoot-through pattern");

endmodule

bind pulse_decoder_with_stepper_drive pdsd_props u_pdsd_props (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.data_out    (data_out),
	.coils       (coils),
	.next_period (next_period),
	.motor_idle  (motor_idle),
	.sequin_bit  (sequin_bit)
);

// ----- test/pdsd_checker.sv -----
// ----------------------------------------------------------------------------
// pdsd_checker
// Watches the item, result and register-write channels of the pulse decoder
// with stepper drive. Keeps its own copy of the decoder, stepper and register
// state, works out the result of every accepted item and compares each
// result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdsd_tb_pkg;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_STEP = 1'b1
	} op_t;

endpackage

module pdsd_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             op,
	input  logic                             data_in,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             data_out,
	input  logic [pdsd_pkg::COIL_W-1:0]      coils,
	input  logic [pdsd_pkg::PERIOD_W-1:0]    next_period,
	input  logic                             motor_idle,
	input  logic                             sequin_bit,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [pdsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pdsd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               mismatches,
	output int                               outstanding
);

	import pdsd_pkg::*;
	import pdsd_tb_pkg::*;

	typedef enum logic [2:0] {
		DEC_IDLE   = 3'd0,
		DEC_START  = 3'd1,
		DEC_MARK   = 3'd2,
		DEC_SAMPLE = 3'd3,
		DEC_GAP    = 3'd4,
		DEC_ECHO   = 3'd5
	} dec_state_t;

	typedef struct packed {
		logic                level;
		logic [COIL_W-1:0]   drive;
		logic [PERIOD_W-1:0] period;
		logic                idle;
		logic                seq;
	} drive_out_t;

	// half-step coil pattern per phase, nibble i holds phase i
	localparam logic [63:0] HALF_STEP_SEQ = 64'h0000_0009_8A26_4510;

	cfg_t                regs;
	dec_state_t          dec_state;
	logic [TICK_BITS-1:0] ticks;
	logic                level;
	logic                seq_now;
	logic                seq_prev;
	logic [PHASE_W-1:0]  phase;
	logic [PERIOD_W-1:0] period;
	logic [STEP_W-1:0]   steps_rem;
	dir_t                dir;
	logic                run_idle;
	logic [COIL_W-1:0]   drive;

	drive_out_t pending_outputs[$];
	drive_out_t want;
	int         errs;

	initial begin
		mismatches  = 0;
		outstanding = 0;
		errs        = 0;
	end

	task automatic report(input string what, input int got, input int exp_val);
		errs++;
		if (errs <= 40)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
	endtask

	task automatic clear_state();
		regs      = '{ERROR_TIME_RST, START_TIME_RST, STOP_TIME_RST, STATE_TIME_RST,
		              STEP_COUNT_RST, DEADTIME_RST, PHASE_DELAY_RST};
		dec_state = DEC_IDLE;
		ticks     = '0;
		level     = 1'b0;
		seq_now   = 1'b0;
		seq_prev  = 1'b0;
		phase     = PHASE_RST;
		period    = DEADTIME_RST;
		steps_rem = '0;
		dir       = DIR_STOP;
		run_idle  = 1'b1;
		drive     = '0;
		pending_outputs.delete();
	endtask

	// all compares use the count as it stood before this tick
	task automatic decode_tick(input logic din);
		logic                 clr;
		logic [TICK_BITS-1:0] t;
		clr = 1'b0;
		t   = ticks;
		case (dec_state)
			DEC_IDLE: begin
				clr = 1'b1;
				if (din)
					dec_state = DEC_START;
			end
			DEC_START: begin
				if (t > regs.error_time)
					dec_state = DEC_IDLE;
				// a long enough pulse is taken even when it is also too long
				if (!din) begin
					dec_state = DEC_IDLE;
					if (t > regs.start_time) begin
						dec_state = DEC_MARK;
						clr       = 1'b1;
					end
				end
			end
			DEC_MARK: begin
				level = 1'b1;
				if (t > regs.state_time)
					dec_state = DEC_SAMPLE;
			end
			DEC_SAMPLE: begin
				seq_now   = din;
				dec_state = DEC_GAP;
			end
			DEC_GAP: begin
				if (!din && t > regs.start_time) begin
					clr       = 1'b1;
					dec_state = DEC_ECHO;
				end
				// timeout overrides the gap; bit keeps its sampled value, clear still applies
				if (t > regs.error_time) begin
					dec_state = DEC_IDLE;
					seq_now   = seq_prev;
				end
			end
			DEC_ECHO: begin
				level = din;
				if (din)
					clr = 1'b1;
				if (t > regs.stop_time)
					dec_state = DEC_IDLE;
			end
			default: begin
				dec_state = DEC_IDLE;
			end
		endcase
		if (clr)
			ticks = '0;
		else if (ticks != '1)
			ticks = ticks + 1'b1;

		if (seq_now != seq_prev) begin
			dir       = seq_now ? DIR_FWD : DIR_REV;
			steps_rem = regs.step_count;
			seq_prev  = seq_now;
		end
	endtask

	task automatic advance_stepper();
		if (steps_rem == '0) begin
			run_idle = 1'b1;
			dir      = DIR_STOP;
			drive    = '0;
		end else begin
			if (dir == DIR_FWD)
				phase = phase + 1'b1;
			else if (dir == DIR_REV)
				phase = phase - 1'b1;
			if (phase == '0)
				phase = PHASE_LAST;
			else if (phase > PHASE_LAST)
				phase = PHASE_FIRST;

			if (period == regs.deadtime)
				period = regs.phase_delay;
			else if (period == regs.phase_delay)
				period = regs.deadtime;

			drive     = HALF_STEP_SEQ[phase*4 +: 4];
			steps_rem = steps_rem - 1'b1;
			run_idle  = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ERROR_TIME:  regs.error_time  = cfg_data;
					CFG_START_TIME:  regs.start_time  = cfg_data;
					CFG_STOP_TIME:   regs.stop_time   = cfg_data;
					CFG_STATE_TIME:  regs.state_time  = cfg_data;
					CFG_STEP_COUNT:  regs.step_count  = cfg_data[STEP_W-1:0];
					CFG_DEADTIME:    regs.deadtime    = cfg_data[PERIOD_W-1:0];
					CFG_PHASE_DELAY: regs.phase_delay = cfg_data[PERIOD_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				if (op == OP_STEP)
					advance_stepper();
				else
					decode_tick(data_in);
				pending_outputs.push_back('{level, drive, period, run_idle, seq_now});
			end

			if (out_valid && !out_stall) begin
				if (pending_outputs.size() == 0) begin
					report("result with no item pending", 1, 0);
				end else begin
					want = pending_outputs.pop_front();
					if (data_out !== want.level)
						report("data_out", data_out, want.level);
					if (coils !== want.drive)
						report("coils", coils, want.drive);
					if (next_period !== want.period)
						report("next_period", next_period, want.period);
					if (motor_idle !== want.idle)
						report("motor_idle", motor_idle, want.idle);
					if (sequin_bit !== want.seq)
						report("sequin_bit", sequin_bit, want.seq);
				end
			end
		end
		mismatches  <= errs;
		outstanding <= pending_outputs.size();
	end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the pulse decoder with stepper drive through several register
// settings: a few directed items at reset values, then framed serial
// traffic with random content and noise, mixed with stepper events. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import pdsd_pkg::*;
	import pdsd_tb_pkg::*;

	localparam int PHASE_ITEMS  = 100;
	localparam int N_PHASE      = 5;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 8;
	localparam int TIMEOUT_NS   = 4_000_000;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	op_t                   op         = OP_TICK;
	logic                  data_in    = 1'b0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic                  data_out;
	logic [COIL_W-1:0]     coils;
	logic [PERIOD_W-1:0]   next_period;
	logic                  motor_idle;
	logic                  sequin_bit;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index  = CFG_ERROR_TIME;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	int   mismatches;
	int   outstanding;
	int   n_sent    = 0;
	bit   hold_req  = 1'b0;
	int   tx_run    = 0;
	bit   tx_burst  = 1'b0;
	int   rx_run    = 0;
	bit   rx_burst  = 1'b0;
	cfg_t cur;
	cfg_t plan [N_PHASE];

	pulse_decoder_with_stepper_drive u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.data_in     (data_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_out    (data_out),
		.coils       (coils),
		.next_period (next_period),
		.motor_idle  (motor_idle),
		.sequin_bit  (sequin_bit),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	pdsd_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.data_in     (data_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_out    (data_out),
		.coils       (coils),
		.next_period (next_period),
		.motor_idle  (motor_idle),
		.sequin_bit  (sequin_bit),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

	// idle cycles before the next transfer; some stretches run back to back
	function automatic int pick_wait(inout int run_len, inout bit burst);
		if (run_len == 0) begin
			burst   = ($urandom_range(0, 3) == 0);
			run_len = $urandom_range(8, 40);
		end
		run_len--;
		return burst ? 0 : $urandom_range(0, 13);
	endfunction

	task automatic send_item(input op_t kind, input logic din);
		int w;
		w = pick_wait(tx_run, tx_burst);
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= kind;
		data_in  <= din;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
	endtask

	// a decoder tick, sometimes preceded by a stepper event
	task automatic tick(input logic din);
		if ($urandom_range(0, 3) == 0)
			send_item(OP_STEP, 1'($urandom_range(0, 1)));
		send_item(OP_TICK, din);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// upper bits of the narrow registers carry junk that must be dropped
	task automatic write_all(input cfg_t c);
		write_reg(CFG_ERROR_TIME, c.error_time);
		write_reg(CFG_START_TIME, c.start_time);
		write_reg(CFG_STOP_TIME, c.stop_time);
		write_reg(CFG_STATE_TIME, c.state_time);
		write_reg(CFG_STEP_COUNT, {8'($urandom), c.step_count});
		write_reg(CFG_DEADTIME, {8'($urandom), c.deadtime});
		write_reg(CFG_PHASE_DELAY, {8'($urandom), c.phase_delay});
		cfg_valid <= 1'b0;
		cur = c;
	endtask

	// one serial frame: start pulse, marker, sampled bit, gap, echo, quiet
	task automatic send_frame();
		int   hi_len;
		logic bit_val;
		bit_val = 1'($urandom_range(0, 1));
		repeat ($urandom_range(1, 2)) tick(1'b0);
		tick(1'b1);
		if ($urandom_range(0, 3) != 0)
			hi_len = $urandom_range(cur.start_time + 1, cur.error_time + 1);
		else
			hi_len = $urandom_range(0, cur.error_time + 3);
		repeat (hi_len) tick(1'b1);
		tick(1'b0);
		repeat (cur.state_time + 2) tick(1'($urandom_range(0, 1)));
		tick(bit_val);
		repeat ($urandom_range(0, 2)) tick(1'b1);
		repeat ($urandom_range(1, 2)) tick(1'b0);
		repeat ($urandom_range(0, 6)) tick(1'($urandom_range(0, 1)));
		repeat (cur.stop_time + 2) tick(1'b0);
	endtask

	initial begin : result_sink
		int w;
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				w = pick_wait(rx_run, rx_burst);
				if (w > 0) begin
					out_stall <= 1'b1;
					repeat (w) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int   quota;
		bit   paused;
		cfg_t rnd;
		paused  = 1'b0;
		plan[0] = '{16'd12, 16'd3, 16'd5, 16'd4, 8'd6, 8'd5, 8'd255};
		plan[1] = '{16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd255, 8'd1};
		plan[2] = '{16'd10, 16'd2, 16'd3, 16'd9, 8'd255, 8'd1, 8'd20};
		plan[3] = '{16'd20, 16'd6, 16'd8, 16'd3, 8'd3, 8'd20, 8'd7};
		cur     = '{ERROR_TIME_RST, START_TIME_RST, STOP_TIME_RST, STATE_TIME_RST,
		           STEP_COUNT_RST, DEADTIME_RST, PHASE_DELAY_RST};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: idle stepper, short pulse rejected
		send_item(OP_STEP, 1'b0);
		send_item(OP_STEP, 1'b1);
		send_item(OP_TICK, 1'b0);
		send_item(OP_TICK, 1'b1);
		repeat (3) send_item(OP_TICK, 1'b1);
		send_item(OP_TICK, 1'b0);
		send_item(OP_TICK, 1'b1);
		send_item(OP_STEP, 1'b1);
		send_item(OP_TICK, 1'b0);
		send_item(OP_STEP, 1'b0);

		for (int p = 0; p < N_PHASE; p++) begin
			wait_drained();
			if (p == N_PHASE - 1) begin
				rnd.error_time  = 16'($urandom_range(0, 24));
				rnd.start_time  = 16'($urandom_range(0, 12));
				rnd.stop_time   = 16'($urandom_range(0, 10));
				rnd.state_time  = 16'($urandom_range(0, 12));
				rnd.step_count  = 8'($urandom_range(0, 20));
				rnd.deadtime    = 8'($urandom_range(1, 255));
				rnd.phase_delay = 8'($urandom_range(1, 255));
				write_all(rnd);
			end else begin
				write_all(plan[p]);
			end
			// back up both stages while items keep coming
			if (p == 0)
				hold_req = 1'b1;
			quota = n_sent + PHASE_ITEMS;
			while (n_sent < quota) begin
				if (p == 1 && !paused && n_sent >= quota - PHASE_ITEMS / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 8))
						send_item(op_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				else
					send_frame();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
src/pdsd_pkg.sv
src/pdsd_decoder.sv
src/pdsd_stepper.sv
src/pulse_decoder_with_stepper_drive.sv
src/pdsd_checker.sv
test/pdsd_checker.sv
test/testbench.sv
